/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the Booth multiplier RTL. They
// compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BSM_ASSERT_SAME(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("Same-cycle assertion failed.");

`define BSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("Next-cycle assertion failed.");

`else

`define BSM_ASSERT_SAME(label, clk, rst, ante, cons)

`define BSM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/bsm_pkg.sv */
// ----------------------------------------------------------------------------
// Booth multiplier package
// Field widths, payload types and Booth recoding codes shared by the
// interfaces and the pipeline modules.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int FIELD_W   = 16;
    localparam int PRODUCT_W = 32;

    typedef logic signed [FIELD_W-1:0]   t_field;
    typedef logic signed [PRODUCT_W-1:0] t_product;

    // Booth pair is {current bit, previous bit}.
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

endpackage

/* src/bsm_if.sv */
// ----------------------------------------------------------------------------
// Booth multiplier channels
// Valid/ready channels for operand transactions and product transactions.
// ----------------------------------------------------------------------------
interface bsm_in_if;
    import bsm_pkg::*;

    logic   valid;
    logic   ready;
    t_field multiplier;
    t_field multiplicand;

    modport source (output valid, output multiplier, output multiplicand, input ready);
    modport sink   (input valid, input multiplier, input multiplicand, output ready);
endinterface

interface bsm_out_if;
    import bsm_pkg::*;

    logic     valid;
    logic     ready;
    t_product product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

/* src/bsm_step.sv */
// ----------------------------------------------------------------------------
// Booth step stage
// One radix-2 Booth recoding step followed by a pipeline register. The stage
// holds its transaction until the next stage can take it.
// ----------------------------------------------------------------------------
module bsm_step #(
    parameter int WIDTH = 16,
    parameter int IDX   = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [2*WIDTH-1:0] i_acc,
    input  logic        [WIDTH-1:0]   i_mplier,
    input  logic signed [WIDTH-1:0]   i_mcand,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [2*WIDTH-1:0] o_acc,
    output logic        [WIDTH-1:0]   o_mplier,
    output logic signed [WIDTH-1:0]   o_mcand
);
    import bsm_pkg::*;

    localparam int ACC_W = 2 * WIDTH;

    logic                     r_valid;
    logic signed [ACC_W-1:0]  r_acc;
    logic        [WIDTH-1:0]  r_mplier;
    logic signed [WIDTH-1:0]  r_mcand;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     w_prev;
    logic [1:0]               w_pair;
    logic signed [ACC_W-1:0]  w_term;
    logic                     w_load;

    generate
        if (IDX == 0) begin : g_first
            assign w_prev = 1'b0;
        end else begin : g_rest
            assign w_prev = i_mplier[IDX-1];
        end
    endgenerate

    assign w_pair  = {i_mplier[IDX], w_prev};
    assign w_term  = ACC_W'(i_mcand) <<< IDX;
    assign o_ready = ~r_valid | i_ready;
    assign w_load  = i_valid & o_ready;

    always_comb begin
        case (w_pair)
            BOOTH_ADD: begin
                n_acc = i_acc + w_term;
            end
            BOOTH_SUB: begin
                n_acc = i_acc - w_term;
            end
            default: begin
                n_acc = i_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_acc    <= n_acc;
            r_mplier <= i_mplier;
            r_mcand  <= i_mcand;
        end
    end

    assign o_valid  = r_valid;
    assign o_acc    = r_acc;
    assign o_mplier = r_mplier;
    assign o_mcand  = r_mcand;

endmodule

/* src/booth_signed_multiplier_core.sv */
// ----------------------------------------------------------------------------
// Booth signed multiplier core
// Pipelined radix-2 Booth multiplier for two's-complement operands.
// ----------------------------------------------------------------------------
// Usage:
// Operand transactions arrive on i_in (multiplier, multiplicand) and product
// transactions leave on o_out, both with valid/ready handshakes.
// Each operand is read as its low WIDTH bits in two's complement, and the
// 2*WIDTH-bit product is zero-extended or cut to the 32-bit product field.
// The pipeline has WIDTH stages, one Booth step and one register each.
// One transaction is accepted per cycle unless back-pressure has filled the
// pipeline; throughput is set by the single adder per stage, not by any
// shared unit.
// Each stage takes a new transaction when it is empty or its own content
// moves on, so bubbles collapse while the output is stalled.
// When o_out.ready stays low, the pipeline fills and i_in.ready drops after
// at most WIDTH further transactions; nothing is dropped or repeated.
// Reset clears all stage valid bits; the operand and sum registers are not
// reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module booth_signed_multiplier_core #(
    parameter int WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsm_in_if.sink     i_in,
    bsm_out_if.source  o_out
);
    import bsm_pkg::*;

    localparam int ACC_W = 2 * WIDTH;

    logic                    w_valid  [0:WIDTH];
    logic                    w_ready  [0:WIDTH];
    logic signed [ACC_W-1:0] w_acc    [0:WIDTH];
    logic        [WIDTH-1:0] w_mplier [0:WIDTH];
    logic signed [WIDTH-1:0] w_mcand  [0:WIDTH];

    assign w_valid[0]  = i_in.valid;
    assign i_in.ready  = w_ready[0];
    assign w_acc[0]    = '0;
    assign w_mplier[0] = WIDTH'(i_in.multiplier);
    assign w_mcand[0]  = WIDTH'(i_in.multiplicand);

    generate
        for (genvar k = 0; k < WIDTH; k++) begin : g_stage
            bsm_step #(
                .WIDTH (WIDTH),
                .IDX   (k)
            ) u_step (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_valid  (w_valid[k]),
                .o_ready  (w_ready[k]),
                .i_acc    (w_acc[k]),
                .i_mplier (w_mplier[k]),
                .i_mcand  (w_mcand[k]),
                .o_valid  (w_valid[k+1]),
                .i_ready  (w_ready[k+1]),
                .o_acc    (w_acc[k+1]),
                .o_mplier (w_mplier[k+1]),
                .o_mcand  (w_mcand[k+1])
            );
        end
    endgenerate

    assign w_ready[WIDTH] = o_out.ready;
    assign o_out.valid    = w_valid[WIDTH];
    assign o_out.product  = PRODUCT_W'($unsigned(w_acc[WIDTH]));

    `BSM_ASSERT_SAME(a_product_exact, i_clk, !i_rst_n, o_out.valid,
        o_out.product == PRODUCT_W'($unsigned(ACC_W'($signed(w_mplier[WIDTH]))
            * ACC_W'(w_mcand[WIDTH]))))
    `BSM_ASSERT_SAME(a_ready_chain, i_clk, !i_rst_n, o_out.ready, i_in.ready)
    `BSM_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_out.valid)

endmodule

/* dv/booth_signed_multiplier_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Booth signed multiplier core testbench
// Sends operand pairs through the valid/ready operand channel and checks each
// product in order against a typed value or a Booth-recoding predictor. A
// short table of edge cases comes first, then biased random operands. Traffic
// runs in three phases with different sender and receiver stall rates.
// ----------------------------------------------------------------------------
module booth_signed_multiplier_core_tb;
    import bsm_pkg::*;

    localparam int TB_WIDTH      = 16;
    localparam int NUM_DIRECTED  = 16;
    localparam int NUM_RANDOM    = 1536;
    localparam int DRAIN_CYCLES  = TB_WIDTH + 8;

    typedef struct {
        t_field   mplier;
        t_field   mcand;
        bit       typed_in;
        t_product product;
    } t_vector;

    logic i_clk;
    logic i_rst_n;

    bsm_in_if  op_if ();
    bsm_out_if prod_if ();

    booth_signed_multiplier_core #(
        .WIDTH (TB_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_if),
        .o_out   (prod_if)
    );

    t_product    pending_products [$];
    int unsigned mismatch_count;
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    t_vector     directed_vectors [NUM_DIRECTED];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic t_product booth_product(t_field mplier, t_field mcand);
        logic signed [63:0] scanned;
        logic signed [63:0] addend;
        logic signed [63:0] acc;
        logic               prev;
        logic               cur;
        scanned = mplier;
        addend  = mcand;
        scanned = (scanned <<< (64 - TB_WIDTH)) >>> (64 - TB_WIDTH);
        addend  = (addend <<< (64 - TB_WIDTH)) >>> (64 - TB_WIDTH);
        acc     = '0;
        prev    = 1'b0;
        for (int i = 0; i < TB_WIDTH; i++) begin
            cur = scanned[i];
            case ({cur, prev})
                BOOTH_SUB: begin
                    acc = acc - (addend <<< i);
                end
                BOOTH_ADD: begin
                    acc = acc + (addend <<< i);
                end
                default: begin
                end
            endcase
            prev = cur;
        end
        if (2 * TB_WIDTH < 64) begin
            acc = acc & ((64'sd1 <<< (2 * TB_WIDTH)) - 64'sd1);
        end
        return acc[PRODUCT_W-1:0];
    endfunction

    function automatic t_field pick_operand();
        t_field value;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: value = 16'sh8000;
                    1: value = 16'sh7FFF;
                    2: value = '0;
                    3: value = -16'sd1;
                    default: value = 16'sd1;
                endcase
            end
            1: begin
                value = t_field'($signed($urandom_range(16)) - 8);
            end
            default: begin
                value = t_field'($urandom);
            end
        endcase
        return value;
    endfunction

    task automatic send_operands(t_field mplier, t_field mcand, bit typed_in,
                                 t_product typed_product);
        while ($urandom_range(99) < sender_idle_pct) begin
            op_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        op_if.valid        <= 1'b1;
        op_if.multiplier   <= mplier;
        op_if.multiplicand <= mcand;
        do begin
            @(posedge i_clk);
        end while (!op_if.ready);
        if (typed_in) begin
            pending_products.push_back(typed_product);
        end else begin
            pending_products.push_back(booth_product(mplier, mcand));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prod_if.ready <= 1'b0;
        end else begin
            prod_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_product expected;
        if (i_rst_n && prod_if.valid && prod_if.ready) begin
            if (pending_products.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected product transaction: %0d", prod_if.product);
                end
            end else begin
                expected = pending_products.pop_front();
                if (prod_if.product !== expected) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Product mismatch: expected %0d, actual %0d",
                                 expected, prod_if.product);
                    end
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int unsigned phase_len;
        mismatch_count      = 0;
        sender_idle_pct     = 16;
        receiver_idle_pct   = 48;
        phase_len           = NUM_RANDOM / 3;
        i_rst_n            <= 1'b0;
        op_if.valid        <= 1'b0;
        op_if.multiplier   <= '0;
        op_if.multiplicand <= '0;

        directed_vectors = '{
            '{16'sd0,      16'sd0,      1'b1, 32'sd0},
            '{16'sh7FFF,   16'sh7FFF,   1'b1, 32'sd1073676289},
            '{16'sh8000,   16'sh8000,   1'b1, 32'sd1073741824},
            '{16'sh8000,   16'sh7FFF,   1'b1, -32'sd1073709056},
            '{16'sh7FFF,   16'sh8000,   1'b1, -32'sd1073709056},
            '{-16'sd1,     -16'sd1,     1'b1, 32'sd1},
            '{16'sd1,      -16'sd1,     1'b1, -32'sd1},
            '{16'sh8000,   16'sd1,      1'b1, -32'sd32768},
            '{16'sh8000,   -16'sd1,     1'b1, 32'sd32768},
            '{-16'sd1,     16'sd12345,  1'b1, -32'sd12345},
            '{16'sd1,      16'sh7FFF,   1'b1, 32'sd32767},
            '{16'sh5555,   16'sh1234,   1'b0, 32'sd0},
            '{16'shAAAA,   16'sh7FFF,   1'b0, 32'sd0},
            '{16'sh00FF,   16'sh8000,   1'b0, 32'sd0},
            '{16'shFF00,   16'sh0F0F,   1'b0, 32'sd0},
            '{16'sh7FFE,   -16'sd3,     1'b0, 32'sd0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_vectors[k]) begin
            send_operands(directed_vectors[k].mplier, directed_vectors[k].mcand,
                          directed_vectors[k].typed_in, directed_vectors[k].product);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == phase_len) begin
                sender_idle_pct   = 48;
                receiver_idle_pct = 16;
            end else if (n == 2 * phase_len) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            send_operands(pick_operand(), pick_operand(), 1'b0, '0);
        end
        op_if.valid <= 1'b0;

        while (pending_products.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_products.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* booth_signed_multiplier_core.f */
+incdir+src
src/bsm_pkg.sv
src/bsm_if.sv
src/bsm_step.sv
src/booth_signed_multiplier_core.sv
dv/booth_signed_multiplier_core_tb.sv
